### rtl/rlt_pkg.sv
// ----------------------------------------------------------------------------
// Recursive lock table package
// Shared types, codes and default sizes for the lock table modules.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam int NUM_ENTRIES_DEFAULT = 8;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    localparam int OWNER_W = 31;
    localparam int ADDR_W  = 32;
    localparam int FREED_W = 4;

    localparam logic [FREED_W-1:0] FREED_MAX = 4'd15;

    typedef enum logic [1:0] {
        REQ_ACQUIRE     = 2'd0,
        REQ_RELEASE     = 2'd1,
        REQ_RELEASE_ALL = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_OTHER    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOT_HELD = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    // Action applied to one table entry at the end of a request cycle.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INC,
        OP_DEC,
        OP_CLEAR,
        OP_FILL
    } entry_op_t;

    typedef struct packed {
        req_type_t           req_type;
        logic [OWNER_W-1:0]  owner_id;
        logic [ADDR_W-1:0]   lock_addr;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [FREED_W-1:0]  freed_count;
    } rsp_t;

endpackage

### rtl/rlt_store.sv
// ----------------------------------------------------------------------------
// Lock table entry storage
// Holds owner, address and nesting count of every entry and applies the
// per-entry actions chosen by the lookup logic.
// ----------------------------------------------------------------------------
module rlt_store
    import rlt_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  entry_op_t [NUM_ENTRIES-1:0]             ops,
    input  logic      [OWNER_W-1:0]                 fill_owner,
    input  logic      [ADDR_W-1:0]                  fill_addr,
    output logic      [NUM_ENTRIES-1:0][COUNT_WIDTH-1:0] count,
    output logic      [NUM_ENTRIES-1:0][OWNER_W-1:0]     owner,
    output logic      [NUM_ENTRIES-1:0][ADDR_W-1:0]      address
);

    logic [NUM_ENTRIES-1:0][COUNT_WIDTH-1:0] count_reg;
    logic [NUM_ENTRIES-1:0][COUNT_WIDTH-1:0] count_next;
    logic [NUM_ENTRIES-1:0][OWNER_W-1:0]     owner_reg;
    logic [NUM_ENTRIES-1:0][ADDR_W-1:0]      address_reg;
    logic [NUM_ENTRIES-1:0]                  single_op;
    logic [NUM_ENTRIES-1:0]                  bad_target;

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            count_next[k] = count_reg[k];
            case (ops[k])
                OP_INC:   count_next[k] = count_reg[k] + COUNT_WIDTH'(1);
                OP_DEC:   count_next[k] = count_reg[k] - COUNT_WIDTH'(1);
                OP_CLEAR: count_next[k] = '0;
                OP_FILL:  count_next[k] = COUNT_WIDTH'(1);
                default:  count_next[k] = count_reg[k];
            endcase
            single_op[k] = (ops[k] == OP_INC) || (ops[k] == OP_DEC) || (ops[k] == OP_FILL);
            bad_target[k] = ((ops[k] == OP_FILL) && (count_reg[k] != '0)) ||
                            ((ops[k] == OP_INC || ops[k] == OP_DEC) && (count_reg[k] == '0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Owner and address are only meaningful while the count is nonzero.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            if (ops[k] == OP_FILL)
            begin
                owner_reg[k]   <= fill_owner;
                address_reg[k] <= fill_addr;
            end
        end
    end

    assign count   = count_reg;
    assign owner   = owner_reg;
    assign address = address_reg;

    // A single request touches at most one entry, except release all.
    a_single_target: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(single_op))
        else $error("more than one entry incremented, decremented or filled");

    // Fills go to free entries, increments and decrements to held ones.
    a_target_state: assert property (@(posedge clk) disable iff (!rst_n)
        bad_target == '0)
        else $error("entry action applied to an entry in the wrong state");

endmodule

### rtl/rlt_lookup.sv
// ----------------------------------------------------------------------------
// Lock table lookup
// Compares a registered request against every entry in parallel and decides
// the result and the action for each entry.
// ----------------------------------------------------------------------------
module rlt_lookup
    import rlt_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                                    valid,
    input  req_t                                    req,
    input  logic      [NUM_ENTRIES-1:0][COUNT_WIDTH-1:0] count,
    input  logic      [NUM_ENTRIES-1:0][OWNER_W-1:0]     owner,
    input  logic      [NUM_ENTRIES-1:0][ADDR_W-1:0]      address,
    output entry_op_t [NUM_ENTRIES-1:0]             ops,
    output rsp_t                                    rsp
);

    localparam int CNT_W = $clog2(NUM_ENTRIES + 1);

    logic [NUM_ENTRIES-1:0] held;
    logic [NUM_ENTRIES-1:0] own_hit;
    logic [NUM_ENTRIES-1:0] addr_hit;
    logic [NUM_ENTRIES-1:0] at_max;
    logic [NUM_ENTRIES-1:0] rel_hit;
    logic [NUM_ENTRIES-1:0] all_hit;
    logic [NUM_ENTRIES-1:0] first_addr;
    logic [NUM_ENTRIES-1:0] first_free;
    logic [NUM_ENTRIES-1:0] first_rel;
    logic [CNT_W-1:0]       freed_raw;

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            held[k]     = (count[k] != '0);
            own_hit[k]  = (owner[k] == req.owner_id);
            addr_hit[k] = held[k] && (address[k] == req.lock_addr);
            at_max[k]   = &count[k];
        end
    end

    assign rel_hit = addr_hit & own_hit;
    assign all_hit = held & own_hit;

    // Isolate the lowest set bit of each candidate vector.
    assign first_addr = addr_hit & (-addr_hit);
    assign first_free = ~held & (-(~held));
    assign first_rel  = rel_hit & (-rel_hit);

    always_comb
    begin
        freed_raw = '0;
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            freed_raw = freed_raw + CNT_W'(all_hit[k]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_ENTRIES; k++)
        begin
            ops[k] = OP_HOLD;
        end
        rsp.status      = ST_OK;
        rsp.freed_count = '0;

        case (req.req_type)
            REQ_ACQUIRE:
            begin
                if (|addr_hit)
                begin
                    if (|(first_addr & ~own_hit))
                    begin
                        rsp.status = ST_OTHER;
                    end
                    else if (|(first_addr & at_max))
                    begin
                        rsp.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        for (int k = 0; k < NUM_ENTRIES; k++)
                        begin
                            if (valid && first_addr[k])
                            begin
                                ops[k] = OP_INC;
                            end
                        end
                    end
                end
                else if (|first_free)
                begin
                    for (int k = 0; k < NUM_ENTRIES; k++)
                    begin
                        if (valid && first_free[k])
                        begin
                            ops[k] = OP_FILL;
                        end
                    end
                end
                else
                begin
                    rsp.status = ST_FULL;
                end
            end
            REQ_RELEASE:
            begin
                if (|rel_hit)
                begin
                    for (int k = 0; k < NUM_ENTRIES; k++)
                    begin
                        if (valid && first_rel[k])
                        begin
                            ops[k] = OP_DEC;
                        end
                    end
                end
                else
                begin
                    rsp.status = ST_NOT_HELD;
                end
            end
            REQ_RELEASE_ALL:
            begin
                for (int k = 0; k < NUM_ENTRIES; k++)
                begin
                    if (valid && all_hit[k])
                    begin
                        ops[k] = OP_CLEAR;
                    end
                end
                if (32'(freed_raw) > 32'(FREED_MAX))
                begin
                    rsp.freed_count = FREED_MAX;
                end
                else
                begin
                    rsp.freed_count = FREED_W'(freed_raw);
                end
            end
            default:
            begin
                rsp.status = ST_OK;
            end
        endcase
    end

endmodule

### rtl/recursive_lock_table.sv
// ----------------------------------------------------------------------------
// Recursive lock table
// Fixed-size table of recursive locks with acquire, release and release-all.
// ----------------------------------------------------------------------------
// Usage:
// A request transfer happens on a rising clock edge where start is high and
// busy is low. The request carries the request type, the owner id and the
// lock address. Busy never rises in this design, so a new request may be
// presented in every cycle and the sustained rate is one request per cycle.
// The request is captured in an input register; in the following cycle all
// entries are compared against it in parallel, a priority encoder picks the
// matching or the lowest free entry, and the table and the result register
// are updated together at the end of that cycle. The result (status and
// freed count) is on the result port, marked by done, for exactly one cycle,
// after the request has passed the input register and the result register. The
// receiver cannot hold results off, so nothing ever waits on the output side.
// Because the table is updated in the same cycle in which the next request
// is captured, a request always sees the effects of every earlier one.
// Reset clears all nesting counts, which frees every entry, and drops any
// request or result in flight. Owner and address storage is not reset; it
// is only read for entries whose count is nonzero.
// ----------------------------------------------------------------------------
module recursive_lock_table
    import rlt_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    logic                                    req_valid_reg;
    req_t                                    req_reg;
    logic                                    done_reg;
    rsp_t                                    rsp_reg;
    rsp_t                                    rsp_next;
    entry_op_t [NUM_ENTRIES-1:0]             ops;
    logic      [NUM_ENTRIES-1:0][COUNT_WIDTH-1:0] count;
    logic      [NUM_ENTRIES-1:0][OWNER_W-1:0]     owner;
    logic      [NUM_ENTRIES-1:0][ADDR_W-1:0]      address;
    logic                                    accept;

    // The lookup is a single combinational pass, so requests are never held
    // off.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Input register. The payload only matters while the valid flag is set.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
    end

    // Parallel compare and decision for the captured request.
    rlt_lookup #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lookup (
        .valid   (req_valid_reg),
        .req     (req_reg),
        .count   (count),
        .owner   (owner),
        .address (address),
        .ops     (ops),
        .rsp     (rsp_next)
    );

    // Entry storage; updated at the same edge as the result register.
    rlt_store #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ops        (ops),
        .fill_owner (req_reg.owner_id),
        .fill_addr  (req_reg.lock_addr),
        .count      (count),
        .owner      (owner),
        .address    (address)
    );

    // Result register: one strobe per captured request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    // Every captured request produces exactly one result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |=> done_reg)
        else $error("captured request produced no result");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        !req_valid_reg |=> !done_reg)
        else $error("result strobe without a captured request");

    // Only a release-all reports freed entries, and it always reports ok.
    a_freed_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && (rsp_reg.freed_count != '0) |-> rsp_reg.status == ST_OK)
        else $error("freed count reported with a failing status");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Recursive lock table testbench
// This testbench drives acquire, release and release-all requests into the
// lock table. A behavioral copy of the table predicts each response. Every
// response from the block is compared, field by field, with the oldest
// prediction that is still waiting.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rlt_pkg::*;

    // The sizes of the block under test. The local copy of the table is built
    // with the same sizes.
    localparam int TB_ENTRIES = NUM_ENTRIES_DEFAULT;
    localparam int TB_COUNT_W = COUNT_WIDTH_DEFAULT;
    localparam logic [TB_COUNT_W-1:0] DEPTH_MAX = {TB_COUNT_W{1'b1}};

    // Request code 3 is not used by the block. It must change nothing.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 750;
    localparam int OWNER_POOL     = 4;
    localparam int ADDR_POOL      = 12;
    // Nesting depth reached by the deep nesting test.
    localparam int NEST_LEVELS    = 16;
    // A response leaves through the input register and the result register, so a
    // short drain is enough once nothing is outstanding.
    localparam int DRAIN_CYCLES   = 8;
    // Idle gaps from random_gap are far shorter than this. Any stretch this long
    // with no transfer at all means the block has hung.
    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t request;
    rsp_t result;

    // This is the local copy of the lock table. Owner and address are only
    // looked at where the nesting depth is nonzero, the same as in the block.
    logic [OWNER_W-1:0]    tbl_owner [TB_ENTRIES];
    logic [ADDR_W-1:0]     tbl_addr  [TB_ENTRIES];
    logic [TB_COUNT_W-1:0] tbl_depth [TB_ENTRIES];

    // These are predicted responses, oldest first, one per accepted request.
    rsp_t pending_responses[$];
    rsp_t want;

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    recursive_lock_table #(
        .NUM_ENTRIES(TB_ENTRIES),
        .COUNT_WIDTH(TB_COUNT_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic req_t make_req(logic [1:0] kind, logic [OWNER_W-1:0] who,
                                      logic [ADDR_W-1:0] where);
        req_t r;
        r = {kind, who, where};
        return r;
    endfunction

    // This applies one request to the local table and returns the response
    // that the block must give for it.
    function automatic rsp_t predict_lock_response(req_t r);
        rsp_t rsp;
        int   slot;
        int   freed;
        rsp.status      = ST_OK;
        rsp.freed_count = '0;
        case (r.req_type)
            REQ_ACQUIRE:
            begin
                slot = -1;
                for (int k = 0; k < TB_ENTRIES; k++)
                begin
                    if (tbl_depth[k] == '0)
                    begin
                        if (slot < 0)
                            slot = k;
                    end
                    else if (tbl_addr[k] == r.lock_addr)
                    begin
                        // The entry that already holds the address decides,
                        // whether the table has free room or not.
                        if (tbl_owner[k] != r.owner_id)
                            rsp.status = ST_OTHER;
                        else if (tbl_depth[k] == DEPTH_MAX)
                            rsp.status = ST_OVERFLOW;
                        else
                            tbl_depth[k] = tbl_depth[k] + 1'b1;
                        return rsp;
                    end
                end
                if (slot < 0)
                    rsp.status = ST_FULL;
                else
                begin
                    tbl_owner[slot] = r.owner_id;
                    tbl_addr[slot]  = r.lock_addr;
                    tbl_depth[slot] = TB_COUNT_W'(1);
                end
            end
            REQ_RELEASE:
            begin
                rsp.status = ST_NOT_HELD;
                for (int k = 0; k < TB_ENTRIES; k++)
                begin
                    if (tbl_depth[k] != '0 && tbl_addr[k] == r.lock_addr &&
                        tbl_owner[k] == r.owner_id)
                    begin
                        tbl_depth[k] = tbl_depth[k] - 1'b1;
                        rsp.status   = ST_OK;
                        break;
                    end
                end
            end
            REQ_RELEASE_ALL:
            begin
                freed = 0;
                for (int k = 0; k < TB_ENTRIES; k++)
                begin
                    if (tbl_depth[k] != '0 && tbl_owner[k] == r.owner_id)
                    begin
                        tbl_depth[k] = '0;
                        freed++;
                    end
                end
                rsp.freed_count = (freed > FREED_MAX) ? FREED_MAX : FREED_W'(freed);
            end
            default:
            begin
                // The unused request code leaves the table as it is.
            end
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // This presents one request and holds it until a transfer takes place.
    // The task is entered at a falling edge and also returns at one, so the
    // next request can follow directly without start ever dropping.
    task automatic send_item(req_t r);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        pending_responses.push_back(predict_lock_response(r));
        @(negedge clk);
    endtask

    // This idles the request side for the given number of cycles. The request bus carries
    // garbage meanwhile, which the block must ignore.
    task automatic pause(int cycles);
        if (cycles > 0)
        begin
            start   <= 1'b0;
            request <= req_t'({1'($urandom), $urandom, $urandom});
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Most gaps are short. A few are long, so the idle time falls on
    // every stage of the pipeline.
    function automatic int random_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(0, 2);
        return $urandom_range(3, 40);
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Response checking
    // ------------------------------------------------------------------------

    // Every response is valid for exactly one cycle, so each one is taken at
    // the rising edge that ends that cycle and matched with the oldest
    // prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_responses.size() == 0)
                report_mismatch("response with no request outstanding");
            else
            begin
                want = pending_responses.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result.status, want.status));
                if (result.freed_count !== want.freed_count)
                    report_mismatch($sformatf("freed_count got %0d want %0d",
                                              result.freed_count, want.freed_count));
            end
        end
    end

    // The watchdog counts cycles with neither a request transfer nor a
    // response. A hang shows up as a long quiet stretch.
    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || (rst_n && done))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // This covers single-entry behavior at the extremes of owner and address:
    // re-entry, unwinding, a release that finds nothing, a collision with
    // another owner, the unused request code, and a release-all that finds
    // nothing held.
    task automatic test_basic_locking();
        logic [OWNER_W-1:0] top_owner;
        logic [ADDR_W-1:0]  top_addr;
        top_owner = '1;
        top_addr  = '1;
        send_item(make_req(REQ_ACQUIRE, '0, '0));
        send_item(make_req(REQ_ACQUIRE, '0, '0));
        send_item(make_req(REQ_RELEASE, '0, '0));
        send_item(make_req(REQ_RELEASE, '0, '0));
        send_item(make_req(REQ_RELEASE, '0, '0));
        send_item(make_req(REQ_ACQUIRE, top_owner, top_addr));
        send_item(make_req(REQ_ACQUIRE, '0, top_addr));
        send_item(make_req(REQ_RELEASE, '0, top_addr));
        send_item(make_req(REQ_UNUSED, top_owner, top_addr));
        send_item(make_req(REQ_RELEASE_ALL, top_owner, '0));
        send_item(make_req(REQ_RELEASE_ALL, top_owner, top_addr));
    endtask

    // Two owners fill the table. Then the test checks a request that finds
    // the table full, re-entry and a foreign collision while the table is full,
    // the refill of a hole, and release-all with several entries per owner.
    task automatic test_table_full();
        logic [OWNER_W-1:0] owner_a;
        logic [OWNER_W-1:0] owner_b;
        owner_a = 31'h1234_5678;
        owner_b = 31'h6dcb_a987;
        for (int k = 0; k < TB_ENTRIES; k++)
        begin
            pause(k % 3);
            send_item(make_req(REQ_ACQUIRE, (k % 2 == 0) ? owner_a : owner_b,
                               32'h4000_0000 + 32'(k) * 32'h0101_0101));
        end
        send_item(make_req(REQ_ACQUIRE, owner_a, 32'hffff_0000));
        send_item(make_req(REQ_ACQUIRE, owner_a, 32'h4000_0000 + 32'h0202_0202));
        send_item(make_req(REQ_ACQUIRE, owner_a, 32'h4000_0000 + 32'h0303_0303));
        send_item(make_req(REQ_RELEASE, owner_a, 32'h4000_0000));
        send_item(make_req(REQ_ACQUIRE, owner_b, 32'hffff_0000));
        send_item(make_req(REQ_ACQUIRE, owner_a, 32'h0000_0001));
        send_item(make_req(REQ_RELEASE_ALL, owner_a, 32'h4000_0000));
        send_item(make_req(REQ_RELEASE_ALL, owner_b, '1));
        send_item(make_req(REQ_RELEASE_ALL, owner_b, '1));
    endtask

    // This nests one entry several levels deep back to back and unwinds it
    // again, with one release too many at the end. Reaching the full nesting
    // depth takes 2^16 - 1 acquires, far longer than this run, so the overflow
    // limit itself is left to the predictor.
    task automatic test_deep_nesting();
        logic [OWNER_W-1:0] who;
        logic [ADDR_W-1:0]  where;
        who   = 31'h2a5a_5a5a;
        where = 32'h8000_0001;
        for (int n = 0; n < NEST_LEVELS; n++)
            send_item(make_req(REQ_ACQUIRE, who, where));
        for (int n = 0; n <= NEST_LEVELS; n++)
            send_item(make_req(REQ_RELEASE, who, where));
        send_item(make_req(REQ_ACQUIRE, who, where));
        send_item(make_req(REQ_ACQUIRE, who, where));
        send_item(make_req(REQ_RELEASE_ALL, who, '0));
    endtask

    // The random part uses small pools of owners and addresses, so requests
    // collide, re-enter, fill the table and unwind again. A share of noise
    // with fully random fields and the unused code is mixed in, and so are
    // broken sequences such as releases of locks that are not held. The pools
    // are drawn again every phase. Every third phase, starting with the first,
    // is back-to-back traffic; the other phases have idle gaps.
    task automatic test_random_traffic();
        logic [OWNER_W-1:0] owner_pool [OWNER_POOL];
        logic [ADDR_W-1:0]  addr_pool  [ADDR_POOL];
        logic [OWNER_W-1:0] who;
        logic [ADDR_W-1:0]  where;
        bit                 with_gaps;
        int                 pick;
        req_t               r;
        with_gaps = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 75 == 0)
            begin
                for (int k = 0; k < OWNER_POOL; k++)
                    owner_pool[k] = OWNER_W'($urandom);
                for (int k = 0; k < ADDR_POOL; k++)
                    addr_pool[k] = $urandom;
                // Some phases include the extreme owner and address values.
                if ($urandom_range(0, 1) == 1)
                begin
                    owner_pool[0] = '0;
                    owner_pool[1] = '1;
                    addr_pool[0]  = '0;
                    addr_pool[1]  = '1;
                end
                with_gaps = ((n / 75) % 3) != 0;
            end
            who   = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
            where = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
            pick  = $urandom_range(0, 99);
            if (pick < 45)
                r = make_req(REQ_ACQUIRE, who, where);
            else if (pick < 78)
                r = make_req(REQ_RELEASE, who, where);
            else if (pick < 86)
                r = make_req(REQ_RELEASE_ALL, who, $urandom);
            else if (pick < 94)
                r = make_req(2'($urandom_range(0, 3)), OWNER_W'($urandom), $urandom);
            else if (pick < 97)
                r = make_req(REQ_RELEASE, who, $urandom);
            else
                r = make_req(REQ_RELEASE_ALL, OWNER_W'($urandom), where);
            if (with_gaps)
                pause(random_gap());
            send_item(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        // After reset every entry of the table is free.
        for (int k = 0; k < TB_ENTRIES; k++)
        begin
            tbl_owner[k] = '0;
            tbl_addr[k]  = '0;
            tbl_depth[k] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_basic_locking();
        test_table_full();
        test_deep_nesting();
        test_random_traffic();

        start <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/rlt_pkg.sv
rtl/rlt_store.sv
rtl/rlt_lookup.sv
rtl/recursive_lock_table.sv
dv/testbench.sv
